// ----- rtl/xsr_pkg.sv -----
// shared constants and helpers for the xorshift64* range generator
`default_nettype none

package xsr_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned HalfWidth = DataWidth / 2;
   localparam int unsigned CountWidth = $clog2(DataWidth);

   localparam logic [DataWidth-1:0] DefaultSeed = 64'h853c_49e6_748f_ea9b;
   localparam logic [DataWidth-1:0] StarMult = 64'h2545_f491_4f6c_dd1d;

   localparam int unsigned ShiftA = 12;
   localparam int unsigned ShiftB = 25;
   localparam int unsigned ShiftC = 27;

   localparam logic CmdRaw = 1'b0;
   localparam logic CmdRange = 1'b1;

   typedef logic [DataWidth-1:0] word_type;
   typedef logic signed [DataWidth-1:0] sword_type;

   function automatic word_type xorshift_step(input word_type s);
      word_type t;
      t = s ^ (s >> ShiftA);
      t = t ^ (t << ShiftB);
      t = t ^ (t >> ShiftC);
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/xsr_channels.sv -----
// request and response channel interfaces
`default_nettype none

interface xsr_req_if;
   import xsr_pkg::*;
   logic valid;
   logic ready;
   logic command;
   sword_type range_low;
   sword_type range_high;

   modport source (output valid, command, range_low, range_high, input ready);
   modport sink (input valid, command, range_low, range_high, output ready);
endinterface

interface xsr_rsp_if;
   import xsr_pkg::*;
   logic valid;
   logic ready;
   sword_type random_value;

   modport source (output valid, random_value, input ready);
   modport sink (input valid, random_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/xorshift64star_range_generator_unit.sv -----
// xorshift64* generator with range reduction, iterative multiply and divide
// range requests run 64 restoring divide steps on one shared 66-bit adder
// one request in flight; a new beat is taken once the result sits in the response register, while it waits there
// reset: synchronous, state = default seed, no result pending
`default_nettype none

module xorshift64star_range_generator_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   xsr_req_if.sink                req_channel,
   xsr_rsp_if.source              rsp_channel,
   input  wire logic              csr_write_enable,
   input  wire xsr_pkg::word_type csr_write_data
);
   import xsr_pkg::*;

   typedef enum logic [3:0] {
      IDLE_S, XS_S, MUL0_S, MUL1_S, MUL2_S, MUL3_S, DIV_S, FIN_S, DONE_S
   } state_type;

   state_type             state_ff;
   logic                  cmd_ff;
   word_type              low_ff;
   word_type              span_ff;
   word_type              gen_state_ff;
   logic [DataWidth-1:0]  prod_ff;
   word_type              acc_ff;
   word_type              rem_ff;
   logic [CountWidth-1:0] count_ff;
   word_type              result_ff;
   logic                  rsp_valid_ff;
   word_type              rsp_data_ff;

   logic                  req_fire;
   logic                  empty_range;
   logic [HalfWidth-1:0]  mul_a;
   logic [HalfWidth-1:0]  mul_b;
   logic [DataWidth+1:0]  alu_a;
   logic [DataWidth+1:0]  alu_b;
   logic                  alu_sub;
   logic [DataWidth+1:0]  alu_sum;
   word_type              raw_value;

   assign req_channel.ready = (state_ff == IDLE_S);
   assign req_fire = req_channel.valid && req_channel.ready;
   assign empty_range = (req_channel.command == CmdRange)
                        && (req_channel.range_high <= req_channel.range_low);

   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.random_value = sword_type'(rsp_data_ff);

   // partial product operands
   always_comb begin
      case (state_ff)
         MUL1_S: begin
            mul_a = gen_state_ff[DataWidth-1:HalfWidth];
            mul_b = StarMult[HalfWidth-1:0];
         end
         MUL2_S: begin
            mul_a = gen_state_ff[HalfWidth-1:0];
            mul_b = StarMult[DataWidth-1:HalfWidth];
         end
         default: begin
            mul_a = gen_state_ff[HalfWidth-1:0];
            mul_b = StarMult[HalfWidth-1:0];
         end
      endcase
   end

   // shared adder
   always_comb begin
      case (state_ff)
         DIV_S: begin
            alu_a = {1'b0, rem_ff, acc_ff[DataWidth-1]};
            alu_b = {2'b00, span_ff};
            alu_sub = 1'b1;
         end
         FIN_S: begin
            alu_a = {2'b00, low_ff};
            alu_b = {2'b00, rem_ff};
            alu_sub = 1'b0;
         end
         default: begin
            alu_a = {2'b00, acc_ff};
            alu_b = {2'b00, prod_ff[HalfWidth-1:0], {HalfWidth{1'b0}}};
            alu_sub = 1'b0;
         end
      endcase
      alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(DataWidth+1){1'b0}}, alu_sub};
   end

   assign raw_value = {1'b0, alu_sum[DataWidth-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_S;
         rsp_valid_ff <= 1'b0;
         gen_state_ff <= DefaultSeed;
      end else begin
         if (rsp_valid_ff && rsp_channel.ready && state_ff != DONE_S) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE_S: begin
               if (req_fire) begin
                  cmd_ff <= req_channel.command;
                  low_ff <= word_type'(req_channel.range_low);
                  span_ff <= word_type'(req_channel.range_high)
                             - word_type'(req_channel.range_low);
                  if (empty_range) begin
                     result_ff <= word_type'(req_channel.range_low);
                     state_ff <= DONE_S;
                  end else begin
                     state_ff <= XS_S;
                  end
               end
            end
            XS_S: begin
               state_ff <= MUL0_S;
            end
            MUL0_S: begin
               prod_ff <= mul_a * mul_b;
               state_ff <= MUL1_S;
            end
            MUL1_S: begin
               acc_ff <= prod_ff;
               prod_ff <= mul_a * mul_b;
               state_ff <= MUL2_S;
            end
            MUL2_S: begin
               acc_ff <= alu_sum[DataWidth-1:0];
               prod_ff <= mul_a * mul_b;
               state_ff <= MUL3_S;
            end
            MUL3_S: begin
               if (cmd_ff == CmdRaw) begin
                  result_ff <= raw_value;
                  state_ff <= DONE_S;
               end else begin
                  acc_ff <= raw_value;
                  rem_ff <= '0;
                  count_ff <= CountWidth'(DataWidth - 1);
                  state_ff <= DIV_S;
               end
            end
            DIV_S: begin
               // restoring divide, one quotient bit per cycle
               if (alu_sum[DataWidth+1]) begin
                  rem_ff <= alu_a[DataWidth-1:0];
               end else begin
                  rem_ff <= alu_sum[DataWidth-1:0];
               end
               acc_ff <= {acc_ff[DataWidth-2:0], 1'b0};
               count_ff <= count_ff - CountWidth'(1);
               if (count_ff == '0) begin
                  state_ff <= FIN_S;
               end
            end
            FIN_S: begin
               result_ff <= alu_sum[DataWidth-1:0];
               state_ff <= DONE_S;
            end
            DONE_S: begin
               if (!rsp_valid_ff || rsp_channel.ready) begin
                  rsp_data_ff <= result_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= IDLE_S;
               end
            end
            default: begin
               state_ff <= IDLE_S;
            end
         endcase
         if (csr_write_enable) begin
            gen_state_ff <= (csr_write_data == '0) ? DefaultSeed : csr_write_data;
         end else if (state_ff == XS_S) begin
            gen_state_ff <= xorshift_step(gen_state_ff);
         end
      end
   end

   a_empty_range_passes_low: assert property (@(posedge clock) disable iff (reset)
      (req_fire && empty_range) |=>
         (state_ff == DONE_S && result_ff == word_type'($past(req_channel.range_low))))
      else $error("empty range did not return the lower bound");

   a_state_holds_in_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_S && !csr_write_enable) |=> $stable(gen_state_ff))
      else $error("generator state moved during divide");

   a_remainder_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_S) |-> (rem_ff < span_ff))
      else $error("partial remainder not below span");

   a_raw_not_negative: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DONE_S && cmd_ff == CmdRaw) |-> !result_ff[DataWidth-1])
      else $error("raw result has sign bit set");

endmodule

`default_nettype wire

// ----- sim/xsr_range_checker.sv -----
// beat monitor, value predictor and comparator for the xorshift64* range generator
module xsr_range_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   xsr_req_if                     req_mon,
   xsr_rsp_if                     rsp_mon,
   input  wire logic              csr_write_enable,
   input  wire xsr_pkg::word_type csr_write_data,
   output int unsigned            mismatch_count,
   output int unsigned            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import xsr_pkg::*;

   localparam int unsigned ReportLimit = 10;
   localparam int unsigned QueueDepth = 16;

   word_type seed_reg;
   word_type gen_state;
   word_type pending_values[QueueDepth];
   int unsigned head_idx;
   int unsigned tail_idx;

   // advances the state only when a draw is needed
   function automatic word_type predict_value(input logic cmd, input word_type lo,
                                              input word_type hi);
      word_type s;
      word_type draw;
      if (cmd == CmdRange && $signed(hi) <= $signed(lo)) begin
         return lo;
      end
      s = gen_state;
      s ^= s >> ShiftA;
      s ^= s << ShiftB;
      s ^= s >> ShiftC;
      gen_state = s;
      draw = (s * StarMult) >> 1;
      if (cmd == CmdRaw) begin
         return draw;
      end
      return lo + draw % (hi - lo);
   endfunction

   always @(posedge clock) begin : monitor
      word_type got;
      word_type want;
      if (reset) begin
         seed_reg = '0;
         gen_state = DefaultSeed;
         head_idx = 0;
         tail_idx = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.random_value;
            if (tail_idx == head_idx) begin
               if (mismatch_count < ReportLimit) begin
                  $display("unexpected random_value beat: got %h", got);
               end
               mismatch_count++;
            end else begin
               want = pending_values[head_idx % QueueDepth];
               head_idx++;
               if (got !== want) begin
                  if (mismatch_count < ReportLimit) begin
                     $display("random_value mismatch: expected %h got %h", want, got);
                  end
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) begin
            seed_reg = csr_write_data;
            gen_state = (seed_reg != '0) ? seed_reg : DefaultSeed;
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_values[tail_idx % QueueDepth] = predict_value(req_mon.command,
                                                                  req_mon.range_low,
                                                                  req_mon.range_high);
            tail_idx++;
         end
      end
      outstanding = tail_idx - head_idx;
   end

endmodule

// ----- sim/xorshift64star_range_generator_unit_tb.sv -----
// testbench top: stimulus, seed writes and verdict for the xorshift64* range generator
module xorshift64star_range_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import xsr_pkg::*;

   localparam int unsigned PhaseCount = 7;
   localparam int unsigned PhaseItems = 133;
   localparam int unsigned MaxGap = 14;
   localparam int unsigned PressureBeat = 100;
   localparam int unsigned LongHold = 400;
   localparam int unsigned DrainCycles = 80;
   localparam word_type MinValue = 64'h8000_0000_0000_0000;
   localparam word_type MaxValue = 64'h7fff_ffff_ffff_ffff;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   word_type csr_write_data;
   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned req_gap_max;
   int unsigned rsp_gap_max;
   int unsigned rsp_beats;

   xsr_req_if req_if();
   xsr_rsp_if rsp_if();

   xorshift64star_range_generator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   xsr_range_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic send_beat(input logic cmd, input word_type lo, input word_type hi);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= cmd;
      req_if.range_low <= lo;
      req_if.range_high <= hi;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_seed(input word_type value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic word_type pick_bound();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 4))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 200)) - 64'd100;
         2: return MinValue + 64'($urandom_range(0, 64));
         3: return MaxValue - 64'($urandom_range(0, 64));
         default: return {{32{r[31]}}, r};
      endcase
   endfunction

   task automatic make_request(output logic cmd, output word_type lo, output word_type hi);
      word_type a;
      word_type b;
      int unsigned kind;
      kind = $urandom_range(0, 99);
      a = pick_bound();
      b = pick_bound();
      cmd = CmdRange;
      lo = a;
      hi = b;
      if (kind < 30) begin
         cmd = CmdRaw;
      end else if (kind < 35) begin
         hi = a;
      end else if (kind < 43) begin
         // inverted bounds
         if ($signed(b) > $signed(a)) begin
            lo = b;
            hi = a;
         end
      end else if (kind < 65) begin
         hi = a + 64'($urandom_range(1, 64));
      end else if (kind < 95) begin
         if ($signed(b) < $signed(a)) begin
            lo = b;
            hi = a;
         end
      end
   endtask

   initial begin : receiver
      int unsigned hold;
      rsp_if.ready = 1'b0;
      rsp_beats = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         hold = (rsp_beats == PressureBeat) ? LongHold : $urandom_range(0, rsp_gap_max);
         if (hold != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_if.valid && rsp_if.ready)) @(posedge clock);
         rsp_beats++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic cmd;
      word_type lo;
      word_type hi;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.command = CmdRaw;
      req_if.range_low = '0;
      req_if.range_high = '0;
      req_gap_max = MaxGap;
      rsp_gap_max = MaxGap;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // raw draws ignore the bounds
      send_beat(CmdRaw, '0, '0);
      send_beat(CmdRaw, MaxValue, MinValue);
      send_beat(CmdRaw, '1, '1);
      // empty ranges return the lower bound
      send_beat(CmdRange, '0, '0);
      send_beat(CmdRange, 64'd5, -64'sd5);
      send_beat(CmdRange, MaxValue, MinValue);
      send_beat(CmdRange, MinValue, MinValue);
      send_beat(CmdRange, MaxValue, MaxValue);
      // wide, unit and assorted spans, plus one raw draw
      send_beat(CmdRange, MinValue, MaxValue);
      send_beat(CmdRange, MinValue, MinValue + 64'd1);
      send_beat(CmdRange, MaxValue - 64'd1, MaxValue);
      send_beat(CmdRange, '1, '0);
      send_beat(CmdRange, '0, 64'd1);
      send_beat(CmdRange, -64'sd100, 64'd100);
      send_beat(CmdRange, MinValue, '0);
      send_beat(CmdRange, '0, MaxValue);
      send_beat(CmdRange, MinValue + 64'd1, MaxValue);
      send_beat(CmdRange, -64'sd3, MaxValue);
      send_beat(CmdRange, 64'd10, 64'd17);
      send_beat(CmdRange, 64'hc000_0000_0000_0000, 64'h4000_0000_0000_0005);
      send_beat(CmdRaw, '0, '0);
      send_beat(CmdRange, 64'd1, 64'h1_0000_0001);

      for (int phase = 0; phase < PhaseCount; phase++) begin
         req_gap_max = (phase % 3 == 1) ? 0 : MaxGap;
         rsp_gap_max = (phase % 4 == 2) ? 0 : MaxGap;
         if (phase != 0) begin
            req_if.valid <= 1'b0;
            while (outstanding != 0) @(negedge clock);
            case (phase)
               1: write_seed('0);
               2: write_seed('1);
               3: write_seed(64'd1);
               4: write_seed(MinValue);
               default: write_seed({$urandom, $urandom});
            endcase
         end
         repeat (PhaseItems) begin
            make_request(cmd, lo, hi);
            send_beat(cmd, lo, hi);
         end
      end
      req_if.valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
